### sv/vad_pkg.sv
// Shared constants and the arctangent table for the distance and direction pipeline.
package vad_pkg;

	localparam int unsigned CORDIC_STEPS = 30;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [15:0] DEG_FULL_Q7 = 16'd46080;
	localparam int unsigned NORM_TOP = 60;

	typedef logic [31:0] turn_t;

	function automatic turn_t atan_turn(input logic [4:0] idx);
		turn_t v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### sv/vad_delay.sv
// Enable-gated delay line that aligns one pipeline branch with another.
module vad_delay #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	generate
		if (DEPTH == 0) begin : g_none
			assign dout = din;
		end else begin : g_line
			logic [WIDTH-1:0] tap_s [DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					tap_s[0] <= din;
					for (int i = 1; i < DEPTH; i++) begin
						tap_s[i] <= tap_s[i-1];
					end
				end
			end
			assign dout = tap_s[DEPTH-1];
		end
	endgenerate

endmodule

### sv/vad_sqrt.sv
// Pipelined rounded square root of dx squared plus dy squared, one root bit per stage.
module vad_sqrt #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH:0]   dx,
	input  logic signed [COORD_WIDTH:0]   dy,
	output logic [COORD_WIDTH:0]          length
);

	localparam int P = COORD_WIDTH + 1;
	localparam int SW = 2 * P;
	localparam int RW = P + 2;

	logic [COORD_WIDTH:0] ax, ay;
	logic [SW-1:0]        sum_s [P+1];
	logic [P-1:0]         root_s [P+1];
	logic [RW-1:0]        rem_s [P+1];
	logic [COORD_WIDTH:0] dist_s;

	assign ax = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - dx : dx;
	assign ay = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - dy : dy;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s[0]  <= SW'(ax * ax) + SW'(ay * ay);
			root_s[0] <= '0;
			rem_s[0]  <= '0;
		end
	end

	generate
		for (genvar j = 0; j < P; j++) begin : g_step
			logic [RW-1:0] rem_n, trial;
			assign rem_n = {rem_s[j][RW-3:0], sum_s[j][2*(P-1-j) +: 2]};
			assign trial = {root_s[j], 2'b01};
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[j+1] <= sum_s[j];
					if (rem_n >= trial) begin
						rem_s[j+1]  <= rem_n - trial;
						root_s[j+1] <= {root_s[j][P-2:0], 1'b1};
					end else begin
						rem_s[j+1]  <= rem_n;
						root_s[j+1] <= {root_s[j][P-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s <= root_s[P] + ((rem_s[P] > RW'(root_s[P])) ? P'(1) : P'(0));
		end
	end

	assign length = dist_s;

endmodule

### sv/vad_cordic.sv
// Normalizing front end, vectoring CORDIC and scaling of the turn angle to radians and degrees.
module vad_cordic #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH:0]   dx,
	input  logic signed [COORD_WIDTH:0]   dy,
	output logic [ANGLE_FRAC_BITS+2:0]    rad,
	output logic [15:0]                   deg
);

	localparam int N = vad_pkg::CORDIC_STEPS;
	localparam int F = ANGLE_FRAC_BITS;
	localparam int SH = 61 - F;
	localparam logic [64:0] RAD_HALF = 65'(1) << (SH - 1);
	localparam logic [F+2:0] FULL_RAD =
		(F+3)'((34'(vad_pkg::TWO_PI_Q29) + (34'(1) << (28 - F))) >> (29 - F));

	logic signed [COORD_WIDTH:0] nx, ny;
	logic [63:0] ux_p1, uy_p1, ux_n1, uy_n1;
	logic        yneg_p1, yneg_n1;
	logic [N+2:0] byp_s, zero_s;
	vad_pkg::turn_t zb_s [N+3];
	logic signed [63:0] x_s [N+1];
	logic signed [63:0] y_s [N+1];
	vad_pkg::turn_t z_s [N+1];
	logic [63:0] ux_a, uy_a, ux_b, uy_b;
	vad_pkg::turn_t zf;
	logic [63:0] prod_r_s;
	logic [47:0] prod_d_s;
	logic [64:0] rad_w;
	logic [48:0] deg_w;
	logic [F+2:0] rad_s;
	logic [15:0] deg_s;

	assign nx = dx[COORD_WIDTH] ? -dx : dx;
	assign ny = dx[COORD_WIDTH] ? -dy : dy;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_p1    <= 64'(unsigned'(nx));
			uy_p1    <= ny[COORD_WIDTH] ? 64'(unsigned'(-ny)) : 64'(unsigned'(ny));
			yneg_p1  <= ny[COORD_WIDTH];
			zb_s[0]  <= dx[COORD_WIDTH] ? vad_pkg::HALF_TURN : '0;
			byp_s[0] <= (dy == '0);
			zero_s[0] <= (dx == '0) && (dy == '0);
		end
	end

	always_comb begin
		logic [63:0] m;
		ux_a = ux_p1;
		uy_a = uy_p1;
		for (int k = 32; k >= 8; k = k / 2) begin
			m = (ux_a > uy_a) ? ux_a : uy_a;
			if (m < (64'(1) << (vad_pkg::NORM_TOP - k))) begin
				ux_a = ux_a << k;
				uy_a = uy_a << k;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_n1   <= ux_a;
			uy_n1   <= uy_a;
			yneg_n1 <= yneg_p1;
		end
	end

	always_comb begin
		logic [63:0] m;
		ux_b = ux_n1;
		uy_b = uy_n1;
		for (int k = 4; k >= 1; k = k / 2) begin
			m = (ux_b > uy_b) ? ux_b : uy_b;
			if (m < (64'(1) << (vad_pkg::NORM_TOP - k))) begin
				ux_b = ux_b << k;
				uy_b = uy_b << k;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= signed'(ux_b);
			y_s[0] <= yneg_n1 ? -signed'(uy_b) : signed'(uy_b);
			zb_s[1]   <= zb_s[0];
			byp_s[1]  <= byp_s[0];
			zero_s[1] <= zero_s[0];
			zb_s[2]   <= zb_s[1];
			byp_s[2]  <= byp_s[1];
			zero_s[2] <= zero_s[1];
		end
	end

	always_comb z_s[0] = zb_s[2];

	generate
		for (genvar i = 0; i < N; i++) begin : g_rot
			logic signed [63:0] xs, ys;
			assign xs = x_s[i] >>> i;
			assign ys = y_s[i] >>> i;
			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_s[i][63]) begin
						x_s[i+1] <= x_s[i] + ys;
						y_s[i+1] <= y_s[i] - xs;
						z_s[i+1] <= z_s[i] + vad_pkg::atan_turn(5'(i));
					end else begin
						x_s[i+1] <= x_s[i] - ys;
						y_s[i+1] <= y_s[i] + xs;
						z_s[i+1] <= z_s[i] - vad_pkg::atan_turn(5'(i));
					end
					zb_s[i+3]   <= zb_s[i+2];
					byp_s[i+3]  <= byp_s[i+2];
					zero_s[i+3] <= zero_s[i+2];
				end
			end
		end
	endgenerate

	assign zf = zero_s[N+2] ? '0 : (byp_s[N+2] ? zb_s[N+2] : z_s[N]);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_r_s <= zf * vad_pkg::TWO_PI_Q29;
			prod_d_s <= zf * vad_pkg::DEG_FULL_Q7;
		end
	end

	assign rad_w = (65'(prod_r_s) + RAD_HALF) >> SH;
	assign deg_w = (49'(prod_d_s) + (49'(1) << 31)) >> 32;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s <= ((F+3)'(rad_w) >= FULL_RAD) ? '0 : (F+3)'(rad_w);
			deg_s <= (16'(deg_w) >= vad_pkg::DEG_FULL_Q7) ? '0 : 16'(deg_w);
		end
	end

	assign rad = rad_s;
	assign deg = deg_s;

endmodule

### sv/vector_angle_distance_2d.sv
// Top level: Euclidean distance and direction between two points, fully pipelined.
// One transaction is accepted per cycle unless the output stalls; each result passes through
// the input difference stage, a three-stage normalizing front end, a 30-stage CORDIC rotator
// and two scaling stages, the last of which drives the output; the distance runs in
// parallel through a square-root pipeline of one root bit per stage. The whole pipeline
// halts while a result is held on the output; direction is in [0, 2 pi) and coincident
// points give zeros.
module vector_angle_distance_2d #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// first_x, first_y, second_x, second_y from the lowest bit up, zero padded.
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// distance, angle_radians, angle_degrees from the lowest bit up, zero padded.
	output logic [((COORD_WIDTH+ANGLE_FRAC_BITS+20+7)/8)*8-1:0] m_tdata
);

	localparam int W = COORD_WIDTH;
	localparam int F = ANGLE_FRAC_BITS;
	localparam int OW = ((W + F + 20 + 7) / 8) * 8;
	localparam int LAT_A = vad_pkg::CORDIC_STEPS + 5;
	localparam int LAT_D = W + 3;
	localparam int LAT = LAT_A + 1;

	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic signed [W:0]    dx_s1, dy_s1;
	logic [W:0]           dist_raw, distance;
	logic [F+2:0]         angle_radians;
	logic [15:0]          angle_degrees;

	assign en = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (W+1)'(signed'(s_tdata[2*W +: W])) - (W+1)'(signed'(s_tdata[0 +: W]));
			dy_s1 <= (W+1)'(signed'(s_tdata[3*W +: W])) - (W+1)'(signed'(s_tdata[W +: W]));
		end
	end

	vad_sqrt #(.COORD_WIDTH(W)) u_sqrt (
		.clk    (clk),
		.en     (en),
		.dx     (dx_s1),
		.dy     (dy_s1),
		.length (dist_raw)
	);

	vad_delay #(.WIDTH(W + 1), .DEPTH(LAT_A - LAT_D)) u_align (
		.clk  (clk),
		.en   (en),
		.din  (dist_raw),
		.dout (distance)
	);

	vad_cordic #(.COORD_WIDTH(W), .ANGLE_FRAC_BITS(F)) u_cordic (
		.clk (clk),
		.en  (en),
		.dx  (dx_s1),
		.dy  (dy_s1),
		.rad (angle_radians),
		.deg (angle_degrees)
	);

	assign m_tdata = OW'({angle_degrees, angle_radians, distance});

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (distance == '0) |-> (angle_radians == '0) && (angle_degrees == '0))
		else $error("zero distance with nonzero direction");

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> angle_degrees < vad_pkg::DEG_FULL_Q7)
		else $error("degree angle not below a full turn");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready ##1 ($stable(vld_q) && $stable(m_tdata)))
		else $error("pipeline moved during output stall");

endmodule
